// ----- src/rti_pkg.sv -----
package rti_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EPS_BITS   = 31;

    // edge / offset vectors, products, cross terms, dot products
    localparam int EW      = COORD_BITS + 1;
    localparam int PW      = 2 * EW;
    localparam int CW      = PW + 1;
    localparam int LO_BITS = CW / 2;
    localparam int HI_BITS = CW - LO_BITS;
    localparam int DW      = EW + CW + 1;

    // divider: numerator, quotient bits, partial remainder
    localparam int NW = DW + FRAC_BITS;
    localparam int QB = COORD_BITS;
    localparam int RW = DW + 1;

    // input beat to result beat, in cycles
    localparam int LATENCY = 10 + QB;

    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int LANE_T = 2;

    typedef enum logic [1:0] {
        CAUSE_HIT      = 2'd0,
        CAUSE_PARALLEL = 2'd1,
        CAUSE_U_OUT    = 2'd2,
        CAUSE_V_OUT    = 2'd3
    } cause_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPS      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         miss_cause;
        logic signed [31:0] dist_res;
        logic [16:0]        bary_u;
        logic [16:0]        bary_v;
    } result_t;

    typedef struct packed {
        cause_t cause;
        logic   tneg;
    } div_meta_t;

endpackage

// ----- src/ray_triangle_intersect_unit.sv -----
// Moller-Trumbore ray/triangle test, fully pipelined: one triangle beat may be
// started every cycle (busy is never raised) and its result appears on
// result with done high after the edge, cross, dot-product, sign and reject
// stages, a restoring divider with 32 quotient-bit stages (most of the depth)
// and the output register. Results come in start order and cannot be
// held off. Ray origin, direction and det_epsilon must only be written while
// no triangle is in flight.
module ray_triangle_intersect_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rti_pkg::tri_in_t   tri_in,
    output logic               done,
    output rti_pkg::result_t   result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata
);

    localparam int EW = rti_pkg::EW;
    localparam int CW = rti_pkg::CW;
    localparam int DW = rti_pkg::DW;
    localparam int NW = rti_pkg::NW;
    localparam int QB = rti_pkg::QB;
    localparam int FB = rti_pkg::FRAC_BITS;

    // ray registers
    logic signed [31:0]              org_reg [3];
    logic signed [31:0]              dir_reg [3];
    logic [rti_pkg::EPS_BITS-1:0]    eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= 32'sd65536;
            eps_reg    <= rti_pkg::EPS_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rti_pkg::REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                rti_pkg::REG_DIR_X:    dir_reg[0] <= cfg_wdata;
                rti_pkg::REG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                rti_pkg::REG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                rti_pkg::REG_EPS:      eps_reg    <= cfg_wdata[rti_pkg::EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: edges and origin offset
    logic signed [EW-1:0] dir_v [3];
    logic signed [EW-1:0] a_v [3];
    logic signed [EW-1:0] b_v [3];
    logic signed [EW-1:0] c_v [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] s_next [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] s_reg [3];
    logic signed [EW-1:0] e1_d2_reg [3];
    logic signed [EW-1:0] e2_d2_reg [3];
    logic signed [EW-1:0] s_d2_reg [3];
    logic signed [EW-1:0] e1_d3_reg [3];
    logic signed [EW-1:0] e2_d3_reg [3];
    logic signed [EW-1:0] s_d3_reg [3];
    logic                 v1_reg;
    logic [6:0]           vsh_reg;

    always_comb
    begin
        a_v[0] = EW'(tri_in.a_x);
        a_v[1] = EW'(tri_in.a_y);
        a_v[2] = EW'(tri_in.a_z);
        b_v[0] = EW'(tri_in.b_x);
        b_v[1] = EW'(tri_in.b_y);
        b_v[2] = EW'(tri_in.b_z);
        c_v[0] = EW'(tri_in.c_x);
        c_v[1] = EW'(tri_in.c_y);
        c_v[2] = EW'(tri_in.c_z);
        for (int i = 0; i < 3; i++)
        begin
            dir_v[i]   = EW'(dir_reg[i]);
            e1_next[i] = b_v[i] - a_v[i];
            e2_next[i] = c_v[i] - a_v[i];
            s_next[i]  = EW'(org_reg[i]) - a_v[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            vsh_reg <= '0;
        end
        else
        begin
            v1_reg  <= start && !busy;
            vsh_reg <= {vsh_reg[5:0], v1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        s_reg     <= s_next;
        e1_d2_reg <= e1_reg;
        e2_d2_reg <= e2_reg;
        s_d2_reg  <= s_reg;
        e1_d3_reg <= e1_d2_reg;
        e2_d3_reg <= e2_d2_reg;
        s_d3_reg  <= s_d2_reg;
    end

    // stages 2-3: p = dir x e2, q = s x e1
    logic signed [CW-1:0] p_v [3];
    logic signed [CW-1:0] q_v [3];

    rti_cross u_cross_p (.clk(clk), .a(dir_v), .b(e2_reg), .c(p_v));
    rti_cross u_cross_q (.clk(clk), .a(s_reg), .b(e1_reg), .c(q_v));

    // stages 4-6: det, u, v and t numerators
    logic signed [DW-1:0] det_w, un_w, vn_w, tn_w;

    rti_dot u_dot_det (.clk(clk), .a(e1_d3_reg), .b(p_v), .dot(det_w));
    rti_dot u_dot_u   (.clk(clk), .a(s_d3_reg),  .b(p_v), .dot(un_w));
    rti_dot u_dot_v   (.clk(clk), .a(dir_v),     .b(q_v), .dot(vn_w));
    rti_dot u_dot_t   (.clk(clk), .a(e2_d3_reg), .b(q_v), .dot(tn_w));

    // stage 7: make det positive, flip numerators with it
    logic [DW-1:0]        adet7_reg;
    logic signed [DW-1:0] un7_reg, vn7_reg, tn7_reg;

    always_ff @(posedge clk)
    begin
        if (det_w[DW-1])
        begin
            adet7_reg <= DW'(-det_w);
            un7_reg   <= -un_w;
            vn7_reg   <= -vn_w;
            tn7_reg   <= -tn_w;
        end
        else
        begin
            adet7_reg <= DW'(det_w);
            un7_reg   <= un_w;
            vn7_reg   <= vn_w;
            tn7_reg   <= tn_w;
        end
    end

    // stage 8: reject tests, divider numerators
    rti_pkg::cause_t      cause8;
    logic                 par8;
    logic [DW:0]          uv_sum;
    logic [DW-1:0]        tabs8;
    logic [DW-1:0]        adet8_reg;
    logic [NW-1:0]        num8_reg [3];
    rti_pkg::div_meta_t   meta8_reg;

    always_comb
    begin
        par8 = (adet7_reg == '0) ||
               (adet7_reg[DW-1:2*FB] < (DW-2*FB)'(eps_reg));
        uv_sum = {1'b0, un7_reg} + {1'b0, vn7_reg};
        if (par8)
        begin
            cause8 = rti_pkg::CAUSE_PARALLEL;
        end
        else if (un7_reg[DW-1] || ($unsigned(un7_reg) > adet7_reg))
        begin
            cause8 = rti_pkg::CAUSE_U_OUT;
        end
        else if (vn7_reg[DW-1] || (uv_sum > {1'b0, adet7_reg}))
        begin
            cause8 = rti_pkg::CAUSE_V_OUT;
        end
        else
        begin
            cause8 = rti_pkg::CAUSE_HIT;
        end
        tabs8 = tn7_reg[DW-1] ? DW'(-tn7_reg) : DW'(tn7_reg);
    end

    always_ff @(posedge clk)
    begin
        adet8_reg                  <= adet7_reg;
        num8_reg[rti_pkg::LANE_U]  <= {un7_reg, {FB{1'b0}}};
        num8_reg[rti_pkg::LANE_V]  <= {vn7_reg, {FB{1'b0}}};
        num8_reg[rti_pkg::LANE_T]  <= {tabs8, {FB{1'b0}}};
        meta8_reg.cause            <= cause8;
        meta8_reg.tneg             <= tn7_reg[DW-1];
    end

    // stages 9..: quotients
    logic                 div_vld;
    logic [QB-1:0]        quo [3];
    logic [2:0]           div_ovf;
    rti_pkg::div_meta_t   div_meta;

    rti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vsh_reg[6]),
        .d        (adet8_reg),
        .num      (num8_reg),
        .meta_in  (meta8_reg),
        .out_vld  (div_vld),
        .quo      (quo),
        .ovf      (div_ovf),
        .meta_out (div_meta)
    );

    // output stage: saturate t, zero a miss
    logic [QB-1:0]     lim;
    logic [QB-1:0]     tq;
    logic              sat;
    rti_pkg::result_t  res_next;
    rti_pkg::result_t  res_reg;
    logic              done_reg;

    always_comb
    begin
        lim = div_meta.tneg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
        sat = div_ovf[rti_pkg::LANE_T] || (quo[rti_pkg::LANE_T] > lim);
        tq  = sat ? lim : quo[rti_pkg::LANE_T];
        res_next            = '0;
        res_next.miss_cause = div_meta.cause;
        if (div_meta.cause == rti_pkg::CAUSE_HIT)
        begin
            res_next.hit      = 1'b1;
            res_next.bary_u   = quo[rti_pkg::LANE_U][FB:0];
            res_next.bary_v   = quo[rti_pkg::LANE_V][FB:0];
            res_next.dist_res = div_meta.tneg ? (~tq + QB'(1)) : tq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // every result beat traces back to a start beat a fixed depth earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rti_pkg::LATENCY))
        else $error("result beat without matching start beat");

    a_hit_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit == (result.miss_cause == rti_pkg::CAUSE_HIT)))
        else $error("hit flag disagrees with miss cause");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |->
            (result.dist_res == '0 && result.bary_u == '0 && result.bary_v == '0))
        else $error("miss beat carries nonzero t/u/v");

    a_uv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |->
            (({1'b0, result.bary_u} + {1'b0, result.bary_v}) <= 18'd65536))
        else $error("u + v exceeds one on a hit");

endmodule

// ----- src/rti_cross.sv -----
module rti_cross (
    input  logic                             clk,
    input  logic signed [rti_pkg::EW-1:0]    a [3],
    input  logic signed [rti_pkg::EW-1:0]    b [3],
    output logic signed [rti_pkg::CW-1:0]    c [3]
);

    logic signed [rti_pkg::PW-1:0] pm_reg [6];
    logic signed [rti_pkg::CW-1:0] c_reg [3];

    always_ff @(posedge clk)
    begin
        pm_reg[0] <= a[1] * b[2];
        pm_reg[1] <= a[2] * b[1];
        pm_reg[2] <= a[2] * b[0];
        pm_reg[3] <= a[0] * b[2];
        pm_reg[4] <= a[0] * b[1];
        pm_reg[5] <= a[1] * b[0];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_reg[i] <= rti_pkg::CW'(pm_reg[2*i]) - rti_pkg::CW'(pm_reg[2*i+1]);
        end
    end

    assign c = c_reg;

endmodule

// ----- src/rti_dot.sv -----
module rti_dot (
    input  logic                             clk,
    input  logic signed [rti_pkg::EW-1:0]    a [3],
    input  logic signed [rti_pkg::CW-1:0]    b [3],
    output logic signed [rti_pkg::DW-1:0]    dot
);

    // b is split into an unsigned low half and a signed high half
    logic signed [rti_pkg::LO_BITS:0]                 lo_s [3];
    logic signed [rti_pkg::HI_BITS-1:0]               hi_s [3];
    logic signed [rti_pkg::EW+rti_pkg::LO_BITS:0]     plo_reg [3];
    logic signed [rti_pkg::EW+rti_pkg::HI_BITS-1:0]   phi_reg [3];
    logic signed [rti_pkg::DW-1:0]                    prod_reg [3];
    logic signed [rti_pkg::DW-1:0]                    sum_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_s[i] = $signed({1'b0, b[i][rti_pkg::LO_BITS-1:0]});
            hi_s[i] = b[i][rti_pkg::CW-1:rti_pkg::LO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            plo_reg[i]  <= a[i] * lo_s[i];
            phi_reg[i]  <= a[i] * hi_s[i];
            prod_reg[i] <= (rti_pkg::DW'(phi_reg[i]) <<< rti_pkg::LO_BITS)
                           + rti_pkg::DW'(plo_reg[i]);
        end
        sum_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
    end

    assign dot = sum_reg;

endmodule

// ----- src/rti_div.sv -----
module rti_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  logic [rti_pkg::DW-1:0]       d,
    input  logic [rti_pkg::NW-1:0]       num [3],
    input  rti_pkg::div_meta_t           meta_in,
    output logic                         out_vld,
    output logic [rti_pkg::QB-1:0]       quo [3],
    output logic [2:0]                   ovf,
    output rti_pkg::div_meta_t           meta_out
);

    localparam int NS = rti_pkg::QB + 1;

    logic                        vld_reg  [NS];
    rti_pkg::div_meta_t          meta_reg [NS];
    logic [rti_pkg::DW-1:0]      d_reg    [NS];
    logic [2:0]                  ovf_reg  [NS];
    logic [rti_pkg::RW-1:0]      rem_reg  [NS][3];
    logic [rti_pkg::QB-1:0]      low_reg  [NS][3];
    logic [rti_pkg::QB-1:0]      q_reg    [NS][3];

    logic [2:0]                  ovf0;
    logic [rti_pkg::RW-1:0]      rem0 [3];

    // quotient overflows QB bits when the top of the numerator reaches d
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ovf0[l] = rti_pkg::RW'(num[l][rti_pkg::NW-1:rti_pkg::QB])
                      >= rti_pkg::RW'(d);
            rem0[l] = ovf0[l] ? '0 : rti_pkg::RW'(num[l][rti_pkg::NW-1:rti_pkg::QB]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= meta_in;
        d_reg[0]    <= d;
        ovf_reg[0]  <= ovf0;
        for (int l = 0; l < 3; l++)
        begin
            rem_reg[0][l] <= rem0[l];
            low_reg[0][l] <= num[l][rti_pkg::QB-1:0];
            q_reg[0][l]   <= '0;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < rti_pkg::QB; k++)
    begin : g_stage
        logic [rti_pkg::RW-1:0] trial [3];
        logic [rti_pkg::RW-1:0] diff  [3];
        logic [2:0]             ge;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {rem_reg[k][l][rti_pkg::RW-2:0],
                            low_reg[k][l][rti_pkg::QB-1]};
                diff[l]  = trial[l] - {1'b0, d_reg[k]};
                ge[l]    = trial[l] >= {1'b0, d_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            meta_reg[k+1] <= meta_reg[k];
            d_reg[k+1]    <= d_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[k+1][l] <= ge[l] ? diff[l] : trial[l];
                low_reg[k+1][l] <= {low_reg[k][l][rti_pkg::QB-2:0], 1'b0};
                q_reg[k+1][l]   <= {q_reg[k][l][rti_pkg::QB-2:0], ge[l]};
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign meta_out = meta_reg[NS-1];
    assign ovf      = ovf_reg[NS-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quo[l] = q_reg[NS-1][l];
        end
    end

endmodule
